FILE: sv/blsq_pkg.sv
// Shared types, constants and helpers for the batch squared L2 distance block.
`timescale 1ns / 1ps

package blsq_pkg;

  localparam int unsigned MAX_LENGTH   = 1024;
  localparam int unsigned ELEMENT_BITS = 16;
  localparam int unsigned ADDR_W       = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned SUM_W        = 43;
  localparam int unsigned DIST_W       = 42;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned SQ_W         = 2 * ELEMENT_BITS;
  localparam int unsigned LEN_RESET    = 128;

  typedef enum logic {
    FUNC_QUERY    = 1'b0,
    FUNC_DATABASE = 1'b1
  } func_e;

  typedef struct packed {
    func_e                          func;
    logic signed [ELEMENT_BITS-1:0] element;
  } in_req_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [COUNT_W-1:0] vector_number;
  } out_req_t;

  // Classified request handed from front to back
  typedef struct packed {
    func_e                          func;
    logic [ADDR_W-1:0]              addr;
    logic signed [ELEMENT_BITS-1:0] element;
    logic                           first;
    logic                           last;
    logic [COUNT_W-1:0]             vector_number;
  } cmd_t;

  // Clamp the length register to 1..MAX_LENGTH
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_LENGTH)) begin
      res = LEN_W'(MAX_LENGTH);
    end
    return res;
  endfunction

endpackage

FILE: sv/blsq_front.sv
// Front end: accepts requests, tracks positions and counts, queues classified commands.
`timescale 1ns / 1ps

module blsq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  blsq_pkg::in_req_t req_i,
  output logic             full_o,
  input  logic [blsq_pkg::LEN_W-1:0] len_i,
  output logic             cmd_valid_o,
  output blsq_pkg::cmd_t   cmd_o,
  input  logic             cmd_pop_i
);

  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = CQ_PTR_W + 1;

  logic [blsq_pkg::ADDR_W-1:0]  qpos_q, qpos_d, dpos_q, dpos_d, wpos;
  logic [blsq_pkg::COUNT_W-1:0] vcnt_q, vcnt_d;
  logic [blsq_pkg::LEN_W-1:0]   qnext, dnext;
  logic                         accept, do_pop;
  blsq_pkg::cmd_t               cmd_in;

  blsq_pkg::cmd_t               cq_mem [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]          head_q, tail_q;
  logic [CQ_CNT_W-1:0]          cnt_q;

  assign full_o      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = cq_mem[head_q];

  always_comb begin
    qpos_d = qpos_q;
    dpos_d = dpos_q;
    vcnt_d = vcnt_q;
    wpos   = (blsq_pkg::LEN_W'(qpos_q) >= len_i) ? '0 : qpos_q;
    qnext  = blsq_pkg::LEN_W'(wpos) + 1'b1;
    dnext  = blsq_pkg::LEN_W'(dpos_q) + 1'b1;

    cmd_in.func          = req_i.func;
    cmd_in.element       = req_i.element;
    cmd_in.addr          = dpos_q;
    cmd_in.first         = (dpos_q == '0);
    cmd_in.last          = (dnext >= len_i);
    cmd_in.vector_number = vcnt_q;

    if (req_i.func == blsq_pkg::FUNC_QUERY) begin
      cmd_in.addr  = wpos;
      cmd_in.first = 1'b0;
      cmd_in.last  = 1'b0;
      if (accept) begin
        qpos_d = (qnext >= len_i) ? '0 : qnext[blsq_pkg::ADDR_W-1:0];
        dpos_d = '0;
        vcnt_d = '0;
      end
    end else if (accept) begin
      if (cmd_in.last) begin
        dpos_d = '0;
        vcnt_d = vcnt_q + 1'b1;
      end else begin
        dpos_d = dnext[blsq_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q <= '0;
      dpos_q <= '0;
      vcnt_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      qpos_q <= qpos_d;
      dpos_q <= dpos_d;
      vcnt_q <= vcnt_d;
      if (accept) begin
        tail_q <= tail_q + 1'b1;
      end
      if (do_pop) begin
        head_q <= head_q + 1'b1;
      end
      if (accept && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!accept && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cq_mem[tail_q] <= cmd_in;
    end
  end

endmodule

FILE: sv/blsq_back.sv
// Back end: query store, subtract/square/accumulate pipeline and result queue.
`timescale 1ns / 1ps

module blsq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  blsq_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  output blsq_pkg::out_req_t res_o,
  input  logic              pop_i
);

  localparam int unsigned EB       = blsq_pkg::ELEMENT_BITS;
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = RQ_PTR_W + 1;

  typedef struct packed {
    logic                         first;
    logic                         last;
    logic [blsq_pkg::COUNT_W-1:0] vector_number;
  } tag_t;

  logic signed [EB-1:0]     qstore [blsq_pkg::MAX_LENGTH];
  logic signed [EB-1:0]     qdata_q;

  logic                     s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [EB-1:0]     s1_el_q;
  tag_t                     s1_tag_q, s2_tag_q, s3_tag_q;
  logic [EB-1:0]            s2_mag_q;
  logic [blsq_pkg::SQ_W-1:0] s3_sq_q;
  logic [blsq_pkg::SUM_W-1:0] acc_q, sum;

  logic signed [EB:0]       diff;
  logic [EB:0]              mag_w;
  logic [1:0]               inflight;
  logic                     room, issue, res_we, res_re;

  blsq_pkg::out_req_t       rq_mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]      rq_head_q, rq_tail_q;
  logic [RQ_CNT_W-1:0]      rq_cnt_q;

  // Count results still in the pipe so the result queue never overflows
  assign inflight = {1'b0, s1_vld_q && s1_tag_q.last} + {1'b0, s2_vld_q && s2_tag_q.last}
                  + {1'b0, s3_vld_q && s3_tag_q.last};
  assign room      = ({1'b0, rq_cnt_q} + {{(RQ_CNT_W-1){1'b0}}, inflight})
                     < (RQ_CNT_W + 1)'(RQ_DEPTH);
  assign issue     = cmd_valid_i && room;
  assign cmd_pop_o = issue;

  assign diff  = {s1_el_q[EB-1], s1_el_q} - {qdata_q[EB-1], qdata_q};
  assign mag_w = diff[EB] ? -diff : diff;

  assign sum    = (s3_tag_q.first ? '0 : acc_q) + blsq_pkg::SUM_W'(s3_sq_q);
  assign res_we = s3_vld_q && s3_tag_q.last;

  assign empty_o = (rq_cnt_q == '0);
  assign res_re  = pop_i && !empty_o;
  assign res_o   = rq_mem[rq_head_q];

  // Query store: write on query commands, registered read on database commands
  always_ff @(posedge clk_i) begin
    if (issue && cmd_i.func == blsq_pkg::FUNC_QUERY) begin
      qstore[cmd_i.addr] <= cmd_i.element;
    end
    if (issue && cmd_i.func == blsq_pkg::FUNC_DATABASE) begin
      qdata_q <= qstore[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_el_q  <= cmd_i.element;
    s1_tag_q <= '{first: cmd_i.first, last: cmd_i.last,
                  vector_number: cmd_i.vector_number};
    s2_mag_q <= mag_w[EB-1:0];
    s2_tag_q <= s1_tag_q;
    s3_sq_q  <= blsq_pkg::SQ_W'(s2_mag_q) * blsq_pkg::SQ_W'(s2_mag_q);
    s3_tag_q <= s2_tag_q;
    if (res_we) begin
      rq_mem[rq_tail_q] <= '{distance: sum[blsq_pkg::DIST_W-1:0],
                             vector_number: s3_tag_q.vector_number};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      acc_q     <= '0;
      rq_head_q <= '0;
      rq_tail_q <= '0;
      rq_cnt_q  <= '0;
    end else begin
      s1_vld_q <= issue && (cmd_i.func == blsq_pkg::FUNC_DATABASE);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (s3_vld_q) begin
        acc_q <= sum;
      end
      if (res_we) begin
        rq_tail_q <= rq_tail_q + 1'b1;
      end
      if (res_re) begin
        rq_head_q <= rq_head_q + 1'b1;
      end
      if (res_we && !res_re) begin
        rq_cnt_q <= rq_cnt_q + 1'b1;
      end else if (!res_we && res_re) begin
        rq_cnt_q <= rq_cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/batch_squared_l2_distance_top.sv
// Top level of the batch squared L2 distance block: length register and front/back wiring.
`timescale 1ns / 1ps

// Streaming squared Euclidean distance. Load a query vector one element per
// request with func = 0, then stream database vectors one element per request
// with func = 1; after vector_length elements a result carries the exact sum of
// squared differences and the vector's running number since the last query load.
// Loading any query element restarts the database position and the count.
// The block takes one request per clock cycle while the back has room: the query
// store has a single port that serves one query write or one database read each
// cycle, and the subtract, square and accumulate steps are pipelined behind it. A
// last element passes from the request queue through the query store read and
// stages s1, s2 and s3 into the result queue. A four-entry request queue parts
// the front from the back, and an eight-entry result queue lets results wait
// while new requests keep flowing; the back stops taking requests while eight
// results are waiting or still in the pipe. Write vector_length only while the
// block is idle; reading a query entry never loaded is undefined.
module batch_squared_l2_distance_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  blsq_pkg::in_req_t            in_req_i,
  output logic                         empty,
  input  logic                         pop,
  output blsq_pkg::out_req_t           out_req_o,
  input  logic                         cfg_we_i,
  input  logic [blsq_pkg::LEN_W-1:0]   cfg_wdata_i
);

  logic [blsq_pkg::LEN_W-1:0] len_q;
  logic [blsq_pkg::LEN_W-1:0] len_eff;
  logic                       cmd_valid;
  logic                       cmd_pop;
  blsq_pkg::cmd_t             cmd;

  // Hold the length register; reset to the default vector length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= blsq_pkg::LEN_W'(blsq_pkg::LEN_RESET);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Clamp out-of-range lengths once, here, for the front end
  assign len_eff = blsq_pkg::eff_len(len_q);

  // Front: classify each request and advance positions and the vector count
  blsq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .req_i       (in_req_i),
    .full_o      (full),
    .len_i       (len_eff),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back: query store, arithmetic pipeline and result queue
  blsq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .res_o       (out_req_o),
    .pop_i       (pop)
  );

  // A waiting result is never dropped unless it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result lost without a pop");

  // The request queue fills only after an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full raised without an accepted request");

  // A query load never lets a result through the front with no database work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !cmd_valid && !$past(cmd_valid)) |=> empty || $past(cmd_valid, 4))
    else $error("result appeared without a database request");

endmodule
